### rtl/prefix_table_insert_lookup_defines.svh
// Assertion macros for the prefix table block.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef PREFIX_TABLE_INSERT_LOOKUP_DEFINES_SVH
`define PREFIX_TABLE_INSERT_LOOKUP_DEFINES_SVH

// same-cycle implication
`define PTI_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PTI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/pti_pkg.sv
// Shared types and constants of the prefix table block.
// No dependencies.
package pti_pkg;

  localparam int unsigned ENTRIES = 16;
  localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W   = $clog2(ENTRIES + 1);
  localparam int unsigned PFX_W   = 128;

  localparam logic [7:0] FLAGS_KEEP = 8'hff;
  localparam logic [7:0] OPT_NEW    = 8'hff;
  localparam logic [7:0] LEN_MAX    = 8'd128;

  typedef enum logic [1:0] {
    ST_HIT    = 2'd0,
    ST_INSERT = 2'd1,
    ST_MISS   = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef enum logic {
    MODE_ADD    = 1'b0,
    MODE_LOOKUP = 1'b1
  } mode_e;

  typedef enum logic {
    BK_IDLE,
    BK_EXEC
  } back_state_e;

  typedef struct packed {
    mode_e       mode;
    logic [63:0] prefix_hi;
    logic [63:0] prefix_lo;
    logic [7:0]  pfx_len;
    logic [31:0] valid_time;
    logic [31:0] pref_time;
    logic [7:0]  flags;
  } in_item_t;

  typedef struct packed {
    status_e     status;
    logic [3:0]  entry_index;
    logic [7:0]  entry_options;
    logic [31:0] entry_valid_time;
    logic [31:0] entry_pref_time;
  } out_item_t;

  // classified work beat between front and back
  typedef struct packed {
    logic             lookup;
    logic             update;
    logic [PFX_W-1:0] prefix;
    logic [7:0]       len;
    logic [7:0]       flags;
    logic [31:0]      valid_time;
    logic [31:0]      pref_time;
  } work_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
  } back_stat_t;

endpackage

### rtl/pti_front.sv
// Front end: accepts input beats, masks the prefix to its length, classifies
// the request and holds it in a two-deep work queue. Depends on pti_pkg.
module pti_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  pti_pkg::in_item_t item_i,
  output logic              work_valid_o,
  input  logic              work_pop_i,
  output pti_pkg::work_t    work_o
);

  logic [7:0]                bits;
  logic [pti_pkg::PFX_W-1:0] mask;
  pti_pkg::work_t            work_d;
  pti_pkg::work_t            slot_q [2];
  logic                      wr_ptr_q, rd_ptr_q;
  logic [1:0]                cnt_q, cnt_d;
  logic                      push_ok, pop_ok;

  always_comb begin
    bits = (item_i.pfx_len > pti_pkg::LEN_MAX) ? pti_pkg::LEN_MAX : item_i.pfx_len;
    for (int i = 0; i < pti_pkg::PFX_W; i++) begin
      mask[pti_pkg::PFX_W-1-i] = (8'(i) < bits);
    end
  end

  always_comb begin
    work_d.lookup     = (item_i.mode == pti_pkg::MODE_LOOKUP);
    work_d.update     = (item_i.flags != pti_pkg::FLAGS_KEEP);
    work_d.prefix     = {item_i.prefix_hi, item_i.prefix_lo} & mask;
    work_d.len        = item_i.pfx_len;
    work_d.flags      = item_i.flags;
    work_d.valid_time = item_i.valid_time;
    work_d.pref_time  = item_i.pref_time;
  end

  assign full         = (cnt_q == 2'd2);
  assign work_valid_o = (cnt_q != 2'd0);
  assign work_o       = slot_q[rd_ptr_q];
  assign push_ok      = push && !full;
  assign pop_ok       = work_pop_i && work_valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (push_ok && !pop_ok) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_ok && !push_ok) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push_ok) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_ok) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      slot_q[wr_ptr_q] <= work_d;
    end
  end

endmodule

### rtl/pti_back.sv
// Back end: prefix table, match and execute sequencer, two-deep result queue.
// Depends on pti_pkg.
module pti_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                work_valid_i,
  output logic                work_pop_o,
  input  pti_pkg::work_t      work_i,
  output logic                empty,
  input  logic                pop,
  output pti_pkg::out_item_t  result_o,
  output pti_pkg::back_stat_t stat_o
);

  localparam int unsigned N = pti_pkg::ENTRIES;
  localparam int unsigned IW = pti_pkg::IDX_W;
  localparam int unsigned CW = pti_pkg::CNT_W;

  logic [N-1:0]              used_q;
  logic [pti_pkg::PFX_W-1:0] pfx_q [N];
  logic [7:0]                len_q [N];
  logic [7:0]                opt_q [N];
  logic [31:0]               vt_q  [N];
  logic [31:0]               pt_q  [N];
  logic [CW-1:0]             count_q;

  pti_pkg::back_state_e state_q, state_d;
  pti_pkg::work_t       cur_q;
  logic [N-1:0]         match_q, match_d;

  pti_pkg::out_item_t ofifo_q [2];
  logic               ow_q, or_q;
  logic [1:0]         ocnt_q, ocnt_d;
  logic               out_full;

  logic               exec_fire, hit, do_upd, do_ins, tbl_full;
  logic [IW-1:0]      hit_idx, ins_idx;
  pti_pkg::out_item_t res;

  always_comb begin
    for (int e = 0; e < N; e++) begin
      match_d[e] = used_q[e] && (len_q[e] == work_i.len) && (pfx_q[e] == work_i.prefix);
    end
  end

  always_comb begin
    hit_idx = '0;
    for (int e = N - 1; e >= 0; e--) begin
      if (match_q[e]) begin
        hit_idx = IW'(e);
      end
    end
  end

  assign hit      = |match_q;
  assign ins_idx  = count_q[IW-1:0];
  assign tbl_full = (count_q >= CW'(N));
  assign out_full = (ocnt_q == 2'd2);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pti_pkg::BK_IDLE: begin
        if (work_valid_i) begin
          state_d = pti_pkg::BK_EXEC;
        end
      end
      pti_pkg::BK_EXEC: begin
        if (!out_full) begin
          state_d = pti_pkg::BK_IDLE;
        end
      end
      default: state_d = pti_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    work_pop_o = 1'b0;
    exec_fire  = 1'b0;
    unique case (state_q)
      pti_pkg::BK_IDLE: work_pop_o = work_valid_i;
      pti_pkg::BK_EXEC: exec_fire  = !out_full;
      default: ;
    endcase
  end

  always_comb begin
    do_upd = 1'b0;
    do_ins = 1'b0;
    res    = '0;
    priority if (hit) begin
      do_upd               = !cur_q.lookup && cur_q.update;
      res.status           = pti_pkg::ST_HIT;
      res.entry_index      = 4'(hit_idx);
      res.entry_options    = do_upd ? cur_q.flags      : opt_q[hit_idx];
      res.entry_valid_time = do_upd ? cur_q.valid_time : vt_q[hit_idx];
      res.entry_pref_time  = do_upd ? cur_q.pref_time  : pt_q[hit_idx];
    end else if (cur_q.lookup) begin
      res.status = pti_pkg::ST_MISS;
    end else if (tbl_full) begin
      res.status = pti_pkg::ST_FULL;
    end else begin
      do_ins               = 1'b1;
      res.status           = pti_pkg::ST_INSERT;
      res.entry_index      = 4'(ins_idx);
      res.entry_options    = pti_pkg::OPT_NEW;
      res.entry_valid_time = cur_q.valid_time;
      res.entry_pref_time  = cur_q.pref_time;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pti_pkg::BK_IDLE;
      used_q  <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      if (exec_fire && do_ins) begin
        used_q[ins_idx] <= 1'b1;
        count_q         <= count_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (work_pop_o) begin
      cur_q   <= work_i;
      match_q <= match_d;
    end
    if (exec_fire && do_upd) begin
      opt_q[hit_idx] <= cur_q.flags;
      vt_q[hit_idx]  <= cur_q.valid_time;
      pt_q[hit_idx]  <= cur_q.pref_time;
    end
    if (exec_fire && do_ins) begin
      pfx_q[ins_idx] <= cur_q.prefix;
      len_q[ins_idx] <= cur_q.len;
      opt_q[ins_idx] <= pti_pkg::OPT_NEW;
      vt_q[ins_idx]  <= cur_q.valid_time;
      pt_q[ins_idx]  <= cur_q.pref_time;
    end
  end

  // result queue
  logic pop_ok;
  assign empty    = (ocnt_q == 2'd0);
  assign pop_ok   = pop && !empty;
  assign result_o = ofifo_q[or_q];

  always_comb begin
    ocnt_d = ocnt_q;
    if (exec_fire && !pop_ok) begin
      ocnt_d = ocnt_q + 2'd1;
    end else if (pop_ok && !exec_fire) begin
      ocnt_d = ocnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ocnt_q <= 2'd0;
      ow_q   <= 1'b0;
      or_q   <= 1'b0;
    end else begin
      ocnt_q <= ocnt_d;
      if (exec_fire) begin
        ow_q <= ~ow_q;
      end
      if (pop_ok) begin
        or_q <= ~or_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_fire) begin
      ofifo_q[ow_q] <= res;
    end
  end

  assign stat_o.count = count_q;

endmodule

### rtl/prefix_table_insert_lookup.sv
// Top level of the IPv6 prefix table: front classifier, work queue, back table.
// Depends on pti_pkg, pti_front, pti_back and the defines header.
//
//   channel  | beat fires on    | payload
//   ---------+------------------+----------------------
//   input    | push && !full    | item_i   (in_item_t)
//   result   | pop && !empty    | result_o (out_item_t)
//
// The back end pops an item and latches the parallel match of all slots; the
// execute step selects the lowest hit, writes the table and queues the result
// before a new item is popped. Front and result queues are two beats deep each.
// Reset clears slot valid bits and the fill count at once; no clearing pass.
// A full result queue holds the back end in its execute step.
`include "prefix_table_insert_lookup_defines.svh"
module prefix_table_insert_lookup (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  pti_pkg::in_item_t  item_i,
  output logic               empty,
  input  logic               pop,
  output pti_pkg::out_item_t result_o
);

  logic                work_valid, work_pop;
  pti_pkg::work_t      work;
  pti_pkg::back_stat_t stat;

  pti_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .item_i       (item_i),
    .work_valid_o (work_valid),
    .work_pop_i   (work_pop),
    .work_o       (work)
  );

  pti_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .work_valid_i (work_valid),
    .work_pop_o   (work_pop),
    .work_i       (work),
    .empty        (empty),
    .pop          (pop),
    .result_o     (result_o),
    .stat_o       (stat)
  );

  `PTI_ASSERT_NEXT(a_push_lands, push && !full, work_valid, "accepted beat not queued")
  `PTI_ASSERT_IMPL(a_pop_valid, work_pop, work_valid, "work popped from empty queue")
  `PTI_ASSERT_IMPL(a_count_bound, 1'b1, stat.count <= pti_pkg::CNT_W'(pti_pkg::ENTRIES), "fill count overflow")
  `PTI_ASSERT_IMPL(a_idx_filled, !empty && (result_o.status == pti_pkg::ST_HIT || result_o.status == pti_pkg::ST_INSERT), 32'(result_o.entry_index) < 32'(stat.count), "index beyond filled slots")
  `PTI_ASSERT_IMPL(a_miss_zero, !empty && (result_o.status == pti_pkg::ST_MISS || result_o.status == pti_pkg::ST_FULL), result_o.entry_index == 4'd0 && result_o.entry_options == 8'd0 && result_o.entry_valid_time == 32'd0 && result_o.entry_pref_time == 32'd0, "miss result not zeroed")

endmodule
